### sv/skr_pkg.sv
// Shared types and constants for the stack with keyed removal.
package skr_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned KEY_W     = 64;
	localparam int unsigned AGE_W     = 8;
	localparam int unsigned CNT_OUT_W = 5;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} cmd_t;

	typedef struct packed {
		logic                 ok;
		logic [KEY_W-1:0]     popped_key;
		logic [AGE_W-1:0]     popped_age;
		logic [CNT_OUT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [AGE_W-1:0] age;
	} rec_t;

endpackage

### sv/stack_with_keyed_removal.sv
// Top level of the bounded record stack with push, pop, remove-by-key and clear.
//
// Usage. Commands arrive as words on the cmd channel (cmd_valid / cmd_stall) and
// each one yields exactly one response word on the rsp channel (rsp_valid /
// rsp_stall), in command order. A word moves at a rising edge where valid is
// high and stall is low.
// Timing. One command is worked on at a time; cmd_stall is high while it is in
// progress. Push and clear go straight to the done state; pop first reads the
// top entry, and remove searches from the top down, then shifts the entries
// above the match down. Pop and remove on an empty stack go straight to done.
// The response word becomes valid at the edge where the next command can be
// taken. The single read port of the record memory sets the remove time: the
// search reads one entry a cycle; the shift reads one as it writes the one below.
// Stalls. The response sits in an output register; the next command is taken
// while it waits. A finished response is held internally until that register
// is free, and no further command is accepted meanwhile.
// Reset. arst_n clears the fill count and all control state; the stack is
// empty afterwards. The memory contents are not cleared and need not be.
module stack_with_keyed_removal #(
	parameter int unsigned DEPTH = skr_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  skr_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output skr_pkg::rsp_t rsp
);
	import skr_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_POP    = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]       state_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    cnt_m1;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    widx_q;
	logic [KEY_W-1:0] key_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	rec_t          wr_data;
	logic [AW-1:0] rd_addr;
	rec_t          rd_data;

	logic cmd_acc;
	logic rsp_free;
	logic key_hit;
	logic top_hit;
	logic shift_last;
	logic full;

	// Response word with the popped record fields cleared.
	function automatic rsp_t plain_rsp(input logic ok, input logic [CW-1:0] cnt);
		rsp_t r;
		r             = '0;
		r.ok          = ok;
		r.entry_count = CNT_OUT_W'(cnt);
		return r;
	endfunction

	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_acc    = cmd_valid && !cmd_stall;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign cnt_m1     = cnt_q - 1'b1;
	assign full       = (cnt_q == CW'(DEPTH));
	assign key_hit    = (rd_data.key == key_q);
	assign top_hit    = (CW'(idx_q) == cnt_m1);
	assign shift_last = ((CW'(widx_q) + 1'b1) == cnt_m1);

	skr_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Memory port steering. A read is issued every cycle; the address follows
	// the state so that the data is ready when the next state needs it. The
	// shift writes the entry below the one it reads, so a read and a write in
	// the same cycle never meet at one address.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[AW-1:0];
		wr_data = '{key: cmd.key, age: cmd.age};
		rd_addr = cnt_m1[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				wr_en = cmd_acc && (cmd.op == OP_PUSH) && !full;
			end
			ST_SEARCH: begin
				rd_addr = key_hit ? (idx_q + 1'b1) : (idx_q - 1'b1);
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = widx_q;
				wr_data = rd_data;
				rd_addr = widx_q + AW'(2);
			end
			default: begin
				rd_addr = cnt_m1[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						state_q <= ST_DONE;
						case (cmd.op)
							OP_PUSH: begin
								if (!full) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							OP_POP: begin
								if (cnt_q != '0) begin
									cnt_q   <= cnt_m1;
									state_q <= ST_POP;
								end
							end
							OP_REMOVE: begin
								if (cnt_q != '0) begin
									state_q <= ST_SEARCH;
								end
							end
							OP_CLEAR: begin
								cnt_q <= '0;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_POP: begin
					state_q <= ST_DONE;
				end
				ST_SEARCH: begin
					if (key_hit) begin
						if (top_hit) begin
							cnt_q   <= cnt_m1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SHIFT;
						end
					end else if (idx_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_SHIFT: begin
					if (shift_last) begin
						cnt_q   <= cnt_m1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: search pointers, searched key and pending response.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				idx_q <= cnt_m1[AW-1:0];
				key_q <= cmd.key;
				case (cmd.op)
					OP_PUSH:   res_q <= full ? plain_rsp(1'b0, cnt_q)
						: plain_rsp(1'b1, cnt_q + 1'b1);
					OP_POP:    res_q <= plain_rsp(1'b0, cnt_q);
					OP_REMOVE: res_q <= plain_rsp(1'b0, cnt_q);
					OP_CLEAR:  res_q <= plain_rsp(1'b1, '0);
					default:   res_q <= plain_rsp(1'b0, cnt_q);
				endcase
			end
			ST_POP: begin
				// The count was already lowered when the pop was accepted.
				res_q <= '{ok: 1'b1, popped_key: rd_data.key, popped_age: rd_data.age,
					entry_count: CNT_OUT_W'(cnt_q)};
			end
			ST_SEARCH: begin
				widx_q <= idx_q;
				if (key_hit) begin
					res_q <= plain_rsp(1'b1, cnt_m1);
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
			ST_SHIFT: begin
				widx_q <= widx_q + 1'b1;
			end
			default: begin
				widx_q <= widx_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The fill count never passes the depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("fill count above depth");

	// A response only appears after the block has finished a command.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DONE))
		else $error("response without finished command");

	// The shift always copies from an entry that is still held.
	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (CW'(widx_q) < cnt_m1))
		else $error("shift beyond the top entry");

	// A failed operation reports no record.
	a_fail_no_record: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.ok) |-> (rsp.popped_key == '0 && rsp.popped_age == '0))
		else $error("record reported on failure");

endmodule

### sv/skr_mem.sv
// Record store: one write port and one registered read port.
module skr_mem #(
	parameter int unsigned DEPTH = skr_pkg::DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  skr_pkg::rec_t wr_data,
	input  logic [AW-1:0] rd_addr,
	output skr_pkg::rec_t rd_data
);
	import skr_pkg::*;

	rec_t mem [DEPTH];
	rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### tb/sv/stack_record_checker.sv
// Checker for the record stack: predicts every response word and compares it with the block.
module stack_record_checker #(
	parameter int unsigned DEPTH = skr_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  skr_pkg::cmd_t cmd,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  skr_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending,
	output int            checked,
	output int            full_refusals,
	output int            empty_pops,
	output int            remove_hits,
	output int            remove_misses
);
	timeunit 1ns;
	timeprecision 1ps;

	import skr_pkg::*;

	logic [KEY_W-1:0] shadow_key [DEPTH];
	logic [AGE_W-1:0] shadow_age [DEPTH];
	int unsigned      shadow_fill;
	rsp_t             awaited_responses [$];
	int               errors;
	int               n_checked;
	int               n_full;
	int               n_empty;
	int               n_hit;
	int               n_miss;

	// Applies one command to the shadow stack and returns the response it must produce.
	function automatic rsp_t next_stack_response(input cmd_t c);
		rsp_t        r;
		int unsigned slot;
		bit          hit;
		r    = '0;
		slot = 0;
		hit  = 1'b0;
		case (c.op)
			OP_PUSH: begin
				if (shadow_fill < DEPTH) begin
					shadow_key[shadow_fill] = c.key;
					shadow_age[shadow_fill] = c.age;
					shadow_fill++;
					r.ok = 1'b1;
				end else begin
					n_full++;
				end
			end
			OP_POP: begin
				if (shadow_fill != 0) begin
					shadow_fill--;
					r.ok         = 1'b1;
					r.popped_key = shadow_key[shadow_fill];
					r.popped_age = shadow_age[shadow_fill];
				end else begin
					n_empty++;
				end
			end
			OP_REMOVE: begin
				// Only the topmost match goes; everything above it slides down one place.
				for (int i = int'(shadow_fill) - 1; i >= 0 && !hit; i--) begin
					if (shadow_key[i] == c.key) begin
						hit  = 1'b1;
						slot = i;
					end
				end
				if (hit) begin
					for (int unsigned j = slot; j + 1 < shadow_fill; j++) begin
						shadow_key[j] = shadow_key[j+1];
						shadow_age[j] = shadow_age[j+1];
					end
					shadow_fill--;
					n_hit++;
				end else begin
					n_miss++;
				end
				r.ok = hit;
			end
			OP_CLEAR: begin
				shadow_fill = 0;
				r.ok        = 1'b1;
			end
			default: begin
				r.ok = 1'b0;
			end
		endcase
		r.entry_count = CNT_OUT_W'(shadow_fill);
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		rsp_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			awaited_responses.delete();
			errors    = 0;
			n_checked = 0;
			n_full    = 0;
			n_empty   = 0;
			n_hit     = 0;
			n_miss    = 0;
		end else begin
			// A response accepted at this edge belongs to an earlier command, so it is
			// matched before the command accepted at the same edge is predicted.
			if (rsp_valid && !rsp_stall) begin
				if (awaited_responses.size() == 0) begin
					$error("response word arrived with none expected");
					errors++;
				end else begin
					want = awaited_responses.pop_front();
					n_checked++;
					compare_field("ok", 64'(want.ok), 64'(rsp.ok));
					compare_field("popped_key", want.popped_key, rsp.popped_key);
					compare_field("popped_age", 64'(want.popped_age), 64'(rsp.popped_age));
					compare_field("entry_count", 64'(want.entry_count), 64'(rsp.entry_count));
				end
			end
			if (cmd_valid && !cmd_stall)
				awaited_responses.push_back(next_stack_response(cmd));
		end
		fail_count    <= errors;
		pending       <= awaited_responses.size();
		checked       <= n_checked;
		full_refusals <= n_full;
		empty_pops    <= n_empty;
		remove_hits   <= n_hit;
		remove_misses <= n_miss;
	end

endmodule

### tb/sv/stack_with_keyed_removal_test.sv
// Top of the record stack testbench: clock, reset, command stimulus, response stalls and verdict.
module stack_with_keyed_removal_test;
	timeunit 1ns;
	timeprecision 1ps;

	import skr_pkg::*;

	// The longest command is a remove that searches the whole stack and shifts all but one
	// entry, so the quiet tail and the watchdog are set from that.
	localparam int TAIL_CYCLES     = 4 * DEPTH_DEF;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_WORDS    = 500;
	localparam int HOLD_AFTER      = 200;
	localparam int POOL_SIZE       = 6;

	localparam logic [KEY_W-1:0] KEY_ONES  = '1;
	localparam logic [KEY_W-1:0] KEY_TWIN  = 64'h414E_4E41_0000_0000;
	localparam logic [KEY_W-1:0] KEY_DEEP  = 64'h424F_5454_4F4D_0000;

	typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_stall;
	cmd_t  cmd       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	int fail_count;
	int pending;
	int checked;
	int full_refusals;
	int empty_pops;
	int remove_hits;
	int remove_misses;

	int               words_sent  = 0;
	int               burst_left  = 0;
	int               idle_cycles = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	stack_with_keyed_removal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	stack_record_checker track (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd           (cmd),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.full_refusals (full_refusals),
		.empty_pops    (empty_pops),
		.remove_hits   (remove_hits),
		.remove_misses (remove_misses)
	);

	function automatic cmd_t word_of(input logic [1:0] op_code, input logic [KEY_W-1:0] k,
			input logic [AGE_W-1:0] a);
		return '{op_code, k, a};
	endfunction

	function automatic logic [KEY_W-1:0] any_key();
		return {$urandom, $urandom};
	endfunction

	// Offers one word and returns at the edge where it is taken. Words go out in bursts;
	// between bursts valid drops for a random gap. A zero gap leaves valid high, so the
	// burst simply runs on without a second assignment to valid in the same step.
	task automatic offer(input cmd_t w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
		burst_left--;
		cmd       <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		words_sent++;
	endtask

	// Response side. It changes its stall pattern from stretch to stretch: no stalls at all,
	// sparse random stalls, a fixed period, or mostly stalled. Once, after a couple of hundred
	// words, it holds off for a long stretch so that the output register and the internal
	// holding slot fill up and the block must push back on the command side.
	initial begin : receiver
		stall_mode_t mode;
		int          stretch;
		int          period;
		bit          held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && words_sent >= HOLD_AFTER) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode    = stall_mode_t'($urandom_range(0, 3));
			stretch = $urandom_range(16, 80);
			period  = $urandom_range(2, 5);
			for (int n = 0; n < stretch; n++) begin
				case (mode)
					STALL_NONE:     rsp_stall <= 1'b0;
					STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 2) == 0);
					STALL_PERIODIC: rsp_stall <= (n % period == 0);
					default:        rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// Watchdog: a run in which no word moves on either channel for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int               pick;
		bit               filling;
		logic [1:0]       op_code;
		logic [KEY_W-1:0] k;
		filling = 1'b1;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = any_key();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Pop and remove on an empty stack must both fail.
		offer(word_of(OP_POP, any_key(), 8'hFF));
		offer(word_of(OP_REMOVE, KEY_TWIN, 8'h00));
		// Extreme keys and ages, then two records sharing one key.
		offer(word_of(OP_PUSH, '0, 8'h00));
		offer(word_of(OP_PUSH, KEY_ONES, 8'hFF));
		offer(word_of(OP_PUSH, KEY_TWIN, 8'h5A));
		offer(word_of(OP_PUSH, KEY_TWIN, 8'hA5));
		// Only the upper twin may go; the pop that follows must return the lower one.
		offer(word_of(OP_REMOVE, KEY_TWIN, 8'h00));
		offer(word_of(OP_POP, '0, 8'h00));
		offer(word_of(OP_POP, '0, 8'h00));
		// Clear with one record still held.
		offer(word_of(OP_CLEAR, any_key(), 8'h00));
		// Fill the stack completely with a marked record at the bottom, push once more
		// into the full stack, then remove the bottom record: the longest search and shift.
		offer(word_of(OP_PUSH, KEY_DEEP, 8'h3C));
		for (int i = 1; i < DEPTH_DEF; i++)
			offer(word_of(OP_PUSH, any_key(), 8'($urandom_range(0, 255))));
		offer(word_of(OP_PUSH, any_key(), 8'h77));
		offer(word_of(OP_REMOVE, KEY_DEEP, 8'h00));
		offer(word_of(OP_CLEAR, '0, 8'h00));

		// Random part. Phases that favour pushes are mixed at random with phases that favour pops and
		// removes, so the stack climbs to full and drains to empty repeatedly. Keys mostly
		// come from a small pool, which gives duplicates and removes that find their key;
		// the rest are fully random and usually miss.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 40 == 0)
				filling = $urandom_range(0, 1);
			pick = $urandom_range(0, 99);
			if (filling)
				op_code = (pick < 60) ? OP_PUSH : (pick < 75) ? OP_POP
					: (pick < 97) ? OP_REMOVE : OP_CLEAR;
			else
				op_code = (pick < 25) ? OP_PUSH : (pick < 60) ? OP_POP
					: (pick < 98) ? OP_REMOVE : OP_CLEAR;
			if ((op_code == OP_PUSH && $urandom_range(0, 9) < 7)
					|| (op_code == OP_REMOVE && $urandom_range(0, 9) < 8))
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				k = any_key();
			offer(word_of(op_code, k, 8'($urandom_range(0, 255))));
		end

		// Drain: let the checker see the last command, wait for every response, then give
		// the block a quiet tail in which any stray word would show up.
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending != 0)
			$error("%0d response words never arrived", pending);

		$display("Run covered %0d command words and %0d checked responses, with %0d pushes",
			words_sent, checked, full_refusals);
		$display("refused when full, %0d pops when empty, %0d removes hit and %0d missed.",
			empty_pops, remove_hits, remove_misses);
		if (fail_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### files.f
sv/skr_pkg.sv
sv/skr_mem.sv
sv/stack_with_keyed_removal.sv
tb/sv/stack_record_checker.sv
tb/sv/stack_with_keyed_removal_test.sv
